>>> src/cc20_pkg.sv
// Shared types, constants and round functions for the ChaCha20 stream XOR block.
package cc20_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MIDLO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MIDHI = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE     = 3'd4;

    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    typedef logic [15:0][31:0] words_t;

    typedef struct packed {
        logic [63:0] key_lo;
        logic [63:0] key_midlo;
        logic [63:0] key_midhi;
        logic [63:0] key_hi;
        logic [63:0] nonce;
    } cfg_t;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       msg_last;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_status_t;

    typedef struct packed {
        logic        start;
        logic [63:0] counter;
    } gen_req_t;

    typedef struct packed {
        logic   done;
        words_t block;
    } gen_rsp_t;

    function automatic words_t cc_init(cfg_t cfg, logic [63:0] counter);
        words_t w;
        w[0]  = SIGMA0;
        w[1]  = SIGMA1;
        w[2]  = SIGMA2;
        w[3]  = SIGMA3;
        w[4]  = cfg.key_lo[31:0];
        w[5]  = cfg.key_lo[63:32];
        w[6]  = cfg.key_midlo[31:0];
        w[7]  = cfg.key_midlo[63:32];
        w[8]  = cfg.key_midhi[31:0];
        w[9]  = cfg.key_midhi[63:32];
        w[10] = cfg.key_hi[31:0];
        w[11] = cfg.key_hi[63:32];
        w[12] = counter[31:0];
        w[13] = counter[63:32];
        w[14] = cfg.nonce[31:0];
        w[15] = cfg.nonce[63:32];
        return w;
    endfunction

    // One quarter-round step (one add, xor, rotate) on all four lanes;
    // diag selects the diagonal index pattern.
    function automatic words_t cc_step(words_t w, logic [1:0] step, logic diag);
        words_t     r;
        logic [1:0] li;
        logic [3:0] ia;
        logic [3:0] ib;
        logic [3:0] ic;
        logic [3:0] id;
        logic [31:0] s;
        logic [31:0] x;
        r = w;
        for (int i = 0; i < 4; i++)
        begin
            li = 2'(i);
            ia = {2'b00, li};
            ib = {2'b01, li + {1'b0, diag}};
            ic = {2'b10, li + {diag, 1'b0}};
            id = {2'b11, li + {diag, diag}};
            case (step)
                2'd0:
                begin
                    s = w[ia] + w[ib];
                    x = w[id] ^ s;
                    r[ia] = s;
                    r[id] = {x[15:0], x[31:16]};
                end
                2'd1:
                begin
                    s = w[ic] + w[id];
                    x = w[ib] ^ s;
                    r[ic] = s;
                    r[ib] = {x[19:0], x[31:20]};
                end
                2'd2:
                begin
                    s = w[ia] + w[ib];
                    x = w[id] ^ s;
                    r[ia] = s;
                    r[id] = {x[23:0], x[31:24]};
                end
                default:
                begin
                    s = w[ic] + w[id];
                    x = w[ib] ^ s;
                    r[ic] = s;
                    r[ib] = {x[24:0], x[31:25]};
                end
            endcase
        end
        return r;
    endfunction

endpackage

>>> src/cc20_front.sv
// Input side: accepts message words into a short queue ahead of the keystream back end.
module cc20_front
    import cc20_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] msg_byte,
    input  logic       msg_last,
    output q_status_t  q_status,
    input  logic       q_pop
);

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;

    assign in_ready = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign push     = in_valid && in_ready;

    assign count_next = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{msg_byte: msg_byte, msg_last: msg_last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign q_status.valid = (count_reg != '0);
    assign q_status.item  = mem_reg[rd_ptr_reg];

endmodule

>>> src/cc20_rounds.sv
// Iterative ChaCha block function: one quarter-round step per cycle, then feed-forward add.
module cc20_rounds
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = 10
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  gen_req_t req,
    output gen_rsp_t rsp
);

    localparam int DR_W = $clog2(DOUBLE_ROUNDS);
    localparam logic [DR_W-1:0] DR_LAST = DR_W'(DOUBLE_ROUNDS - 1);

    words_t          words_reg;
    words_t          init;
    logic            busy_reg;
    logic            done_reg;
    logic [1:0]      step_reg;
    logic            diag_reg;
    logic [DR_W-1:0] dr_reg;
    logic            last_step;

    assign init = cc_init(cfg, req.counter);

    assign last_step = busy_reg && (step_reg == 2'd3) && diag_reg && (dr_reg == DR_LAST);

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            words_reg <= init;
        end
        else if (busy_reg)
        begin
            words_reg <= cc_step(words_reg, step_reg, diag_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            diag_reg <= 1'b0;
            dr_reg   <= '0;
        end
        else
        begin
            done_reg <= last_step && !req.start;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                diag_reg <= 1'b0;
                dr_reg   <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 2'd3)
                begin
                    diag_reg <= ~diag_reg;
                    if (diag_reg)
                    begin
                        if (dr_reg == DR_LAST)
                        begin
                            busy_reg <= 1'b0;
                        end
                        else
                        begin
                            dr_reg <= dr_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            rsp.block[i] = words_reg[i] + init[i];
        end
        rsp.done = done_reg;
    end

endmodule

>>> src/cc20_back.sv
// Back end: block sequencing, keystream buffer, byte XOR and output register.
module cc20_back
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = 10
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  q_status_t  q_status,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_GEN  = 2'b10
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    words_t      ks_reg;
    logic [63:0] counter_reg;
    logic [5:0]  pos_reg;
    logic        ready_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;
    gen_req_t    gen_req;
    gen_rsp_t    gen_rsp;

    cc20_rounds #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_rounds (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .req  (gen_req),
        .rsp  (gen_rsp)
    );

    assign ks_word = ks_reg[pos_reg[5:2]];
    assign ks_byte = ks_word[{pos_reg[1:0], 3'b000} +: 8];

    assign gen_req.start   = (state_reg == ST_IDLE) && q_status.valid && !ready_reg;
    assign gen_req.counter = counter_reg;

    assign q_pop = (state_reg == ST_IDLE) && q_status.valid && ready_reg
                   && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (gen_req.start)
                begin
                    state_next = ST_GEN;
                end
            end
            ST_GEN:
            begin
                if (gen_rsp.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (gen_rsp.done)
        begin
            ks_reg <= gen_rsp.block;
        end
        if (q_pop)
        begin
            out_byte_reg <= q_status.item.msg_byte ^ ks_byte;
            out_last_reg <= q_status.item.msg_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            counter_reg   <= '0;
            pos_reg       <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (gen_rsp.done)
            begin
                counter_reg <= counter_reg + 64'd1;
                ready_reg   <= 1'b1;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
                if (q_status.item.msg_last)
                begin
                    counter_reg <= '0;
                    pos_reg     <= '0;
                    ready_reg   <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_reg + 1'b1;
                    if (pos_reg == 6'd63)
                    begin
                        ready_reg <= 1'b0;
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

>>> src/chacha20_stream_xor.sv
// ChaCha20 (64-bit counter, 64-bit nonce) byte stream XOR: top level, config registers, checks.
// Each input word carries one message byte and returns it XORed with the keystream.
// A four-entry input queue decouples the input from the keystream engine. Bytes inside a
// 64-byte block flow at one per cycle while the output is not stalled; the first byte of each
// block waits for the block function, a single shared quarter-round step unit that runs every
// step of DOUBLE_ROUNDS double rounds before the block is handed off. The counter restarts at
// zero after a word marked last.
module chacha20_stream_xor
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           msg_byte,
    input  logic                 msg_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 out_last
);

    cfg_t      cfg_reg;
    q_status_t q_status;
    logic      q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                CFG_KEY_LO:    cfg_reg.key_lo    <= cfg_data;
                CFG_KEY_MIDLO: cfg_reg.key_midlo <= cfg_data;
                CFG_KEY_MIDHI: cfg_reg.key_midhi <= cfg_data;
                CFG_KEY_HI:    cfg_reg.key_hi    <= cfg_data;
                CFG_NONCE:     cfg_reg.nonce     <= cfg_data;
                default:       ;
            endcase
        end
    end

    cc20_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .msg_byte(msg_byte),
        .msg_last(msg_last),
        .q_status(q_status),
        .q_pop   (q_pop)
    );

    cc20_back #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .q_pop    (q_pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte (out_byte),
        .out_last (out_last)
    );

`ifndef ASSERT_OFF
    a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_status.valid)
        else $error("queue popped while empty");

    a_pop_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid)
        else $error("popped word did not reach the output register");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !q_status.valid) |=> q_status.valid)
        else $error("accepted word missing from queue");
`endif

endmodule

>>> verif/tb_chacha20_stream_xor.sv
// Self-checking testbench for chacha20_stream_xor: predicted keystream XOR under random handshakes.
`timescale 1ns / 1ps

module tb_chacha20_stream_xor;
    import cc20_pkg::*;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int DRAIN_CYCLES = 8 * DOUBLE_ROUNDS + 20;
    localparam int PHASE_ITEMS = 230;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_NONCE + 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cipher_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           msg_byte = '0;
    logic                 msg_last = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [7:0]           out_byte;
    logic                 out_last;

    item_t        pending_words[$];
    cipher_word_t expected_words[$];

    // predictor state
    logic [63:0] cfg_shadow [0:4];
    words_t      ks_block;
    logic [63:0] blk_ctr = '0;
    logic [5:0]  byte_pos = '0;
    logic        ks_valid = 1'b0;

    int idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int items_in = 0;
    int results_seen = 0;
    int msgs_done = 0;
    int blocks_made = 0;
    int cfg_sets = 0;

    always #1 clk = ~clk;

    chacha20_stream_xor #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .msg_byte  (msg_byte),
        .msg_last  (msg_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    function automatic logic [31:0] rotl(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic words_t quarter_round(words_t w, int a, int b, int c, int d);
        w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
        return w;
    endfunction

    function automatic words_t chacha_block(logic [63:0] ctr);
        words_t init;
        words_t w;
        init[0]  = SIGMA0;
        init[1]  = SIGMA1;
        init[2]  = SIGMA2;
        init[3]  = SIGMA3;
        init[4]  = cfg_shadow[CFG_KEY_LO][31:0];
        init[5]  = cfg_shadow[CFG_KEY_LO][63:32];
        init[6]  = cfg_shadow[CFG_KEY_MIDLO][31:0];
        init[7]  = cfg_shadow[CFG_KEY_MIDLO][63:32];
        init[8]  = cfg_shadow[CFG_KEY_MIDHI][31:0];
        init[9]  = cfg_shadow[CFG_KEY_MIDHI][63:32];
        init[10] = cfg_shadow[CFG_KEY_HI][31:0];
        init[11] = cfg_shadow[CFG_KEY_HI][63:32];
        init[12] = ctr[31:0];
        init[13] = ctr[63:32];
        init[14] = cfg_shadow[CFG_NONCE][31:0];
        init[15] = cfg_shadow[CFG_NONCE][63:32];
        w = init;
        for (int r = 0; r < DOUBLE_ROUNDS; r++)
        begin
            w = quarter_round(w, 0, 4, 8, 12);
            w = quarter_round(w, 1, 5, 9, 13);
            w = quarter_round(w, 2, 6, 10, 14);
            w = quarter_round(w, 3, 7, 11, 15);
            w = quarter_round(w, 0, 5, 10, 15);
            w = quarter_round(w, 1, 6, 11, 12);
            w = quarter_round(w, 2, 7, 8, 13);
            w = quarter_round(w, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++)
            w[i] = w[i] + init[i];
        return w;
    endfunction

    task automatic cipher_step(input logic [7:0] data, input logic last);
        cipher_word_t res;
        if (!ks_valid)
        begin
            ks_block = chacha_block(blk_ctr);
            blk_ctr = blk_ctr + 64'd1;
            ks_valid = 1'b1;
            blocks_made++;
        end
        res.data = data ^ ks_block[byte_pos[5:2]][{byte_pos[1:0], 3'b000} +: 8];
        res.last = last;
        expected_words.push_back(res);
        byte_pos = byte_pos + 6'd1;
        if (byte_pos == 6'd0)
            ks_valid = 1'b0;
        if (last)
        begin
            blk_ctr = '0;
            byte_pos = '0;
            ks_valid = 1'b0;
            msgs_done++;
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            msg_byte <= '0;
            msg_last <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                cipher_step(msg_byte, msg_last);
                items_in++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    msg_byte <= pending_words[0].msg_byte;
                    msg_last <= pending_words[0].msg_last;
                    void'(pending_words.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cipher_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual data=%02h last=%0b",
                         $time, out_byte, out_last);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                results_seen++;
                if (out_byte !== want.data)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.data, out_byte);
                    errors++;
                end
                if (out_last !== want.last)
                begin
                    $display("%0t: out_last expected %0b actual %0b",
                             $time, want.last, out_last);
                    errors++;
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] rand_data();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic push_word(input logic [7:0] data, input logic last);
        pending_words.push_back('{msg_byte: data, msg_last: last});
    endtask

    task automatic queue_message(input int len, input bit close);
        for (int i = 0; i < len; i++)
            push_word(rand_data(), close && (i == len - 1));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx <= CFG_NONCE)
            cfg_shadow[idx] = val;
    endtask

    task automatic close_cfg();
        @(posedge clk);
        cfg_en <= 1'b0;
        cfg_sets++;
    endtask

    task automatic configure(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3,
                             input logic [63:0] n);
        write_reg(CFG_KEY_LO, k0);
        write_reg(CFG_KEY_MIDLO, k1);
        write_reg(CFG_KEY_MIDHI, k2);
        write_reg(CFG_KEY_HI, k3);
        write_reg(CFG_NONCE, n);
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, 2**CFG_IDX_W - 1)), rand64());
        close_cfg();
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        #2_000_000;
        $display("tb_chacha20_stream_xor NOT OK");
        $finish;
    end

    initial
    begin
        words_t kat;
        int     len;
        int     sent;
        int     r;
        for (int i = 0; i < 5; i++)
            cfg_shadow[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // zero key, zero nonce, block 0 known answer
        kat = chacha_block(64'd0);
        if (kat[0] !== 32'hade0b876 || kat[1] !== 32'h903df1a0 || kat[15] !== 32'h8665eeb2)
        begin
            $display("%0t: zero-key block expected %08h %08h .. %08h actual %08h %08h .. %08h",
                     $time, 32'hade0b876, 32'h903df1a0, 32'h8665eeb2,
                     kat[0], kat[1], kat[15]);
            errors++;
        end

        @(negedge clk);
        for (int i = 0; i < 8; i++)
            push_word(8'h00, i == 7);
        wait_idle();

        configure('1, '1, '1, '1, '1);
        for (int i = CFG_SPARE_FIRST; i < 2**CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), rand64());
        close_cfg();
        @(negedge clk);
        push_word(8'hFF, 1'b1);
        push_word(8'h00, 1'b1);
        push_word(8'hFF, 1'b1);
        push_word(8'hA5, 1'b0);
        push_word(8'h5A, 1'b0);
        push_word(8'h00, 1'b0);
        wait_idle();

        // key change inside an open message: current block keeps the old key
        write_reg(CFG_KEY_LO, rand64());
        write_reg(CFG_NONCE, rand64());
        close_cfg();
        @(negedge clk);
        queue_message(4, 1'b1);
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b1);
        wait_idle();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            case (p)
                0: configure(rand64(), rand64(), rand64(), rand64(), rand64());
                1: configure('0, '0, '0, '0, rand64());
                2: configure({32{2'b01}}, {32{2'b10}}, {32{2'b01}}, {32{2'b10}}, '1);
                default: configure(rand64(), rand64(), rand64(), rand64(), rand64());
            endcase
            @(negedge clk);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    len = $urandom_range(1, 16);
                else if (r < 75)
                    len = $urandom_range(17, 63);
                else if (r < 90)
                    len = $urandom_range(64, 70);
                else
                    len = $urandom_range(100, 200);
                sent += len;
                // even phases end with the message still open
                queue_message(len, !(sent >= PHASE_ITEMS && p % 2 == 0));
            end
            wait_idle();
        end

        $display("Run covered %0d words (%0d checked), %0d closed messages, %0d keystream blocks",
                 items_in, results_seen, msgs_done, blocks_made);
        $display("over %0d key/nonce settings and four handshake mixes", cfg_sets);
        if (errors == 0 && expected_words.size() == 0)
            $display("tb_chacha20_stream_xor OK");
        else
            $display("tb_chacha20_stream_xor NOT OK");
        $finish;
    end

endmodule
